@@ src/rv32i_dec_pkg.sv @@
// ----------------------------------------------------------------------------
// RV32I decoder package
// Request and result types and operation numbers shared by the decoder,
// its pipeline wrapper and its checker.
// ----------------------------------------------------------------------------
package rv32i_dec_pkg;

	// Operation numbers, in the order of the base instruction listing.
	typedef enum logic [5:0] {
		OP_ILLEGAL = 6'd0,
		OP_LUI,
		OP_AUIPC,
		OP_ADD,
		OP_SUB,
		OP_SLL,
		OP_SLT,
		OP_SLTU,
		OP_XOR,
		OP_SRL,
		OP_SRA,
		OP_OR,
		OP_AND,
		OP_SB,
		OP_SH,
		OP_SW,
		OP_ADDI,
		OP_SLTI,
		OP_SLTIU,
		OP_XORI,
		OP_ORI,
		OP_ANDI,
		OP_SLLI,
		OP_SRLI,
		OP_SRAI,
		OP_LB,
		OP_LH,
		OP_LW,
		OP_LBU,
		OP_LHU,
		OP_BEQ,
		OP_BNE,
		OP_BLT,
		OP_BGE,
		OP_BLTU,
		OP_BGEU,
		OP_JAL,
		OP_JALR,
		OP_FENCE,
		OP_ECALL,
		OP_EBREAK
	} op_t;

	// One instruction to decode.
	typedef struct packed {
		logic [31:0] insn;
		logic [31:0] pc;
	} dec_req_t;

	// One decoded instruction.
	typedef struct packed {
		logic [5:0]         op;
		logic [4:0]         rd;
		logic [4:0]         rs1;
		logic [4:0]         rs2;
		logic signed [31:0] imm;
		logic [31:0]        target;
		logic [3:0]         fence_pred;
		logic [3:0]         fence_succ;
	} dec_rsp_t;

endpackage

@@ src/rv32i_instruction_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// RV32I instruction decoder unit
// Two-register pipeline around the RV32I decode logic.
// ----------------------------------------------------------------------------
// The unit takes requests on the input channel (in_valid, in_ready, in_data)
// and returns one decoded result per request on the output channel
// (out_valid, out_ready, out_data), in request order.
// A request is captured in the input register at the edge where it is
// accepted. The decode logic between the input register and the result
// register is a single pass of short logic plus one 32-bit target adder,
// so the result is registered as soon as the result register can load,
// and out_valid stays high from then until the result is taken.
// Throughput is one request per cycle: the unit accepts a new request in
// every cycle in which the input register is empty or the result register
// is free or being emptied.
// When the receiver stalls, the result stays in the result register and
// one more request can still be taken into the input register; after
// that, in_ready falls until out_ready returns.
// Reset clears both valid flags, so no result is pending after reset and
// the unit is ready for a request at once.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder_unit
	import rv32i_dec_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dec_req_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output dec_rsp_t out_data
);

	logic     valid_s1;
	dec_req_t req_s1;
	logic     valid_s2;
	dec_rsp_t rsp_s2;
	dec_rsp_t rsp_comb;
	logic     load_s2;
	logic     take;

	// The result register can load when it is empty or being read out.
	assign load_s2 = !valid_s2 || out_ready;

	// The input register can load when it is empty or moving forward.
	assign in_ready = !valid_s1 || load_s2;
	assign take     = in_valid && in_ready;

	rv32i_dec_logic u_logic (
		.req(req_s1),
		.rsp(rsp_comb)
	);

	// Valid flags are control state and are cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (load_s2) valid_s2 <= valid_s1;
		end
	end

	// Payload registers load only with a valid request behind them.
	always_ff @(posedge clk) begin
		if (take) req_s1 <= in_data;
		if (load_s2 && valid_s1) rsp_s2 <= rsp_comb;
	end

	assign out_valid = valid_s2;
	assign out_data  = rsp_s2;

endmodule

@@ src/rv32i_dec_logic.sv @@
// ----------------------------------------------------------------------------
// RV32I decode logic
// Combinational decode of one instruction word into operation, register
// fields, immediate, branch target and fence bits.
// ----------------------------------------------------------------------------
module rv32i_dec_logic
	import rv32i_dec_pkg::*;
(
	input  dec_req_t req,
	output dec_rsp_t rsp
);

	localparam logic [6:0] OPC_LUI    = 7'b0110111;
	localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
	localparam logic [6:0] OPC_OP     = 7'b0110011;
	localparam logic [6:0] OPC_STORE  = 7'b0100011;
	localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
	localparam logic [6:0] OPC_LOAD   = 7'b0000011;
	localparam logic [6:0] OPC_BRANCH = 7'b1100011;
	localparam logic [6:0] OPC_JAL    = 7'b1101111;
	localparam logic [6:0] OPC_JALR   = 7'b1100111;
	localparam logic [6:0] OPC_FENCE  = 7'b0001111;
	localparam logic [6:0] OPC_SYSTEM = 7'b1110011;

	localparam logic [6:0] F7_BASE = 7'b0000000;
	localparam logic [6:0] F7_ALT  = 7'b0100000;

	logic [31:0] w;
	logic [6:0]  opc;
	logic [2:0]  f3;
	logic [6:0]  f7;
	logic [31:0] imm_i;
	logic [31:0] imm_s;
	logic [31:0] imm_b;
	logic [31:0] imm_j;
	logic [31:0] imm_u;
	logic [31:0] shamt;
	logic [31:0] offset;
	logic [31:0] sum;
	op_t         op;
	logic [31:0] imm;
	logic        use_target;
	logic        is_fence;

	assign w     = req.insn;
	assign opc   = w[6:0];
	assign f3    = w[14:12];
	assign f7    = w[31:25];
	assign imm_i = {{21{w[31]}}, w[30:20]};
	assign imm_s = {{21{w[31]}}, w[30:25], w[11:7]};
	assign imm_b = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
	assign imm_j = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
	assign imm_u = {w[31:12], 12'h000};
	assign shamt = {27'd0, w[24:20]};

	// One adder serves both branch and jal targets.
	assign offset = (opc == OPC_JAL) ? imm_j : imm_b;
	assign sum    = req.pc + offset;

	always_comb begin
		op         = OP_ILLEGAL;
		imm        = 32'd0;
		use_target = 1'b0;
		is_fence   = 1'b0;
		case (opc)
			OPC_LUI: begin
				op  = OP_LUI;
				imm = imm_u;
			end
			OPC_AUIPC: begin
				op  = OP_AUIPC;
				imm = imm_u;
			end
			OPC_OP: begin
				case (f3)
					3'd0: begin
						if (f7 == F7_BASE) op = OP_ADD;
						else if (f7 == F7_ALT) op = OP_SUB;
					end
					3'd1: op = OP_SLL;
					3'd2: op = OP_SLT;
					3'd3: op = OP_SLTU;
					3'd4: op = OP_XOR;
					3'd5: begin
						if (f7 == F7_BASE) op = OP_SRL;
						else if (f7 == F7_ALT) op = OP_SRA;
					end
					3'd6: op = OP_OR;
					default: op = OP_AND;
				endcase
			end
			OPC_STORE: begin
				case (f3)
					3'd0: op = OP_SB;
					3'd1: op = OP_SH;
					3'd2: op = OP_SW;
					default: op = OP_ILLEGAL;
				endcase
				if (op != OP_ILLEGAL) imm = imm_s;
			end
			OPC_OP_IMM: begin
				case (f3)
					3'd0: begin op = OP_ADDI;  imm = imm_i; end
					3'd2: begin op = OP_SLTI;  imm = imm_i; end
					3'd3: begin op = OP_SLTIU; imm = imm_i; end
					3'd4: begin op = OP_XORI;  imm = imm_i; end
					3'd6: begin op = OP_ORI;   imm = imm_i; end
					3'd7: begin op = OP_ANDI;  imm = imm_i; end
					3'd1: begin op = OP_SLLI;  imm = shamt; end
					default: begin
						if (f7 == F7_BASE) begin
							op  = OP_SRLI;
							imm = shamt;
						end else if (f7 == F7_ALT) begin
							op  = OP_SRAI;
							imm = shamt;
						end
					end
				endcase
			end
			OPC_LOAD: begin
				case (f3)
					3'd0: op = OP_LB;
					3'd1: op = OP_LH;
					3'd2: op = OP_LW;
					3'd4: op = OP_LBU;
					3'd5: op = OP_LHU;
					default: op = OP_ILLEGAL;
				endcase
				if (op != OP_ILLEGAL) imm = imm_i;
			end
			OPC_BRANCH: begin
				case (f3)
					3'd0: op = OP_BEQ;
					3'd1: op = OP_BNE;
					3'd4: op = OP_BLT;
					3'd5: op = OP_BGE;
					3'd6: op = OP_BLTU;
					3'd7: op = OP_BGEU;
					default: op = OP_ILLEGAL;
				endcase
				if (op != OP_ILLEGAL) begin
					imm        = imm_b;
					use_target = 1'b1;
				end
			end
			OPC_JAL: begin
				op         = OP_JAL;
				imm        = imm_j;
				use_target = 1'b1;
			end
			OPC_JALR: begin
				op  = OP_JALR;
				imm = imm_i;
			end
			OPC_FENCE: begin
				op       = OP_FENCE;
				is_fence = 1'b1;
			end
			OPC_SYSTEM: begin
				// The whole 12-bit immediate selects ecall or ebreak.
				if (w[31:20] == 12'd0) op = OP_ECALL;
				else if (w[31:20] == 12'd1) op = OP_EBREAK;
				if (op != OP_ILLEGAL) imm = imm_i;
			end
			default: op = OP_ILLEGAL;
		endcase
	end

	assign rsp.op         = op;
	assign rsp.rd         = w[11:7];
	assign rsp.rs1        = w[19:15];
	assign rsp.rs2        = w[24:20];
	assign rsp.imm        = imm;
	assign rsp.target     = use_target ? sum : 32'd0;
	assign rsp.fence_pred = is_fence ? w[27:24] : 4'd0;
	assign rsp.fence_succ = is_fence ? w[23:20] : 4'd0;

endmodule

@@ src/rv32i_dec_checker.sv @@
// ----------------------------------------------------------------------------
// RV32I decoder checker
// Port-level assertions on the decoder unit, bound into the decoder unit.
// ----------------------------------------------------------------------------
module rv32i_dec_checker
	import rv32i_dec_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input dec_req_t in_data,
	input logic     out_valid,
	input logic     out_ready,
	input dec_rsp_t out_data
);

	// A waiting request must hold until it is taken.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request changed while waiting");

	// A stalled result must hold until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// An illegal word carries no immediate, target or fence bits.
	a_illegal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.op == OP_ILLEGAL |->
			out_data.imm == 32'sd0 && out_data.target == 32'd0 &&
			out_data.fence_pred == 4'd0 && out_data.fence_succ == 4'd0)
		else $error("illegal result has nonzero fields");

	// Fence bits are only set for a fence.
	a_fence_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.op != OP_FENCE |->
			out_data.fence_pred == 4'd0 && out_data.fence_succ == 4'd0)
		else $error("fence bits set on a non-fence result");

	// Shift amounts fit in five bits.
	a_shamt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.op == OP_SLLI || out_data.op == OP_SRLI ||
			out_data.op == OP_SRAI) |-> out_data.imm[31:5] == 27'd0)
		else $error("shift amount wider than five bits");

endmodule

bind rv32i_instruction_decoder_unit rv32i_dec_checker u_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.in_data(in_data),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);

@@ verif/rv32i_instruction_decoder_unit_test.sv @@
// ----------------------------------------------------------------------------
// RV32I instruction decoder unit testbench
// Sends instruction words with random addresses through the decoder and
// compares every decoded result with a decode computed here. A short
// directed list covers the encoding corners, then random requests that are
// mostly well-formed instructions exercise every operation. Both channels
// stall at random, except in one long steady stretch.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder_unit_test;
	import rv32i_dec_pkg::*;

	// Major opcodes of the base instruction set.
	localparam logic [6:0] OPC_LUI    = 7'h37;
	localparam logic [6:0] OPC_AUIPC  = 7'h17;
	localparam logic [6:0] OPC_REG    = 7'h33;
	localparam logic [6:0] OPC_STORE  = 7'h23;
	localparam logic [6:0] OPC_IMM    = 7'h13;
	localparam logic [6:0] OPC_LOAD   = 7'h03;
	localparam logic [6:0] OPC_BRANCH = 7'h63;
	localparam logic [6:0] OPC_JAL    = 7'h6f;
	localparam logic [6:0] OPC_JALR   = 7'h67;
	localparam logic [6:0] OPC_FENCE  = 7'h0f;
	localparam logic [6:0] OPC_SYSTEM = 7'h73;

	// The two funct7 values that select between paired operations.
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// System immediates that are legal.
	localparam logic [11:0] SYS_ECALL  = 12'h000;
	localparam logic [11:0] SYS_EBREAK = 12'h001;

	localparam int RANDOM_REQUESTS = 450;
	// The steady stretch, counted in random requests, with no stalls at all.
	localparam int STEADY_FIRST    = 150;
	localparam int STEADY_LAST     = 280;
	localparam int IDLE_PERCENT    = 13;
	localparam int DRAIN_CYCLES    = 10;
	localparam int WATCHDOG_LIMIT  = 1000;

	// Holds the decodes still owed by the unit and checks each result
	// against the oldest of them.
	class decode_scoreboard;
		dec_rsp_t pending_decodes[$];
		int       mismatches = 0;

		// Decodes one instruction word at its address.
		static function dec_rsp_t decode_insn(dec_req_t req);
			logic [31:0] w;
			logic [2:0]  f3;
			logic [6:0]  f7;
			logic [31:0] imm_i;
			logic [31:0] imm_s;
			logic [31:0] imm_b;
			logic [31:0] imm_j;
			op_t         op;
			dec_rsp_t    rsp;
			w     = req.insn;
			f3    = w[14:12];
			f7    = w[31:25];
			imm_i = {{20{w[31]}}, w[31:20]};
			imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
			imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
			imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			op    = OP_ILLEGAL;
			rsp   = '0;
			// Register fields are raw slices whatever the operation is.
			rsp.rd  = w[11:7];
			rsp.rs1 = w[19:15];
			rsp.rs2 = w[24:20];

			case (w[6:0])
				OPC_LUI: begin
					op = OP_LUI;
					rsp.imm = {w[31:12], 12'b0};
				end
				OPC_AUIPC: begin
					op = OP_AUIPC;
					rsp.imm = {w[31:12], 12'b0};
				end
				OPC_REG: begin
					// Only add/sub and srl/sra look at funct7.
					case (f3)
						3'd0: op = (f7 == F7_BASE) ? OP_ADD :
							(f7 == F7_ALT) ? OP_SUB : OP_ILLEGAL;
						3'd1: op = OP_SLL;
						3'd2: op = OP_SLT;
						3'd3: op = OP_SLTU;
						3'd4: op = OP_XOR;
						3'd5: op = (f7 == F7_BASE) ? OP_SRL :
							(f7 == F7_ALT) ? OP_SRA : OP_ILLEGAL;
						3'd6: op = OP_OR;
						default: op = OP_AND;
					endcase
				end
				OPC_STORE: begin
					case (f3)
						3'd0: op = OP_SB;
						3'd1: op = OP_SH;
						3'd2: op = OP_SW;
						default: op = OP_ILLEGAL;
					endcase
					if (op != OP_ILLEGAL) begin
						rsp.imm = imm_s;
					end
				end
				OPC_IMM: begin
					case (f3)
						3'd0: op = OP_ADDI;
						3'd2: op = OP_SLTI;
						3'd3: op = OP_SLTIU;
						3'd4: op = OP_XORI;
						3'd6: op = OP_ORI;
						3'd7: op = OP_ANDI;
						3'd1: op = OP_SLLI;
						default: op = (f7 == F7_BASE) ? OP_SRLI :
							(f7 == F7_ALT) ? OP_SRAI : OP_ILLEGAL;
					endcase
					if (op inside {OP_SLLI, OP_SRLI, OP_SRAI}) begin
						rsp.imm = {27'b0, w[24:20]};
					end else if (op != OP_ILLEGAL) begin
						rsp.imm = imm_i;
					end
				end
				OPC_LOAD: begin
					case (f3)
						3'd0: op = OP_LB;
						3'd1: op = OP_LH;
						3'd2: op = OP_LW;
						3'd4: op = OP_LBU;
						3'd5: op = OP_LHU;
						default: op = OP_ILLEGAL;
					endcase
					if (op != OP_ILLEGAL) begin
						rsp.imm = imm_i;
					end
				end
				OPC_BRANCH: begin
					case (f3)
						3'd0: op = OP_BEQ;
						3'd1: op = OP_BNE;
						3'd4: op = OP_BLT;
						3'd5: op = OP_BGE;
						3'd6: op = OP_BLTU;
						3'd7: op = OP_BGEU;
						default: op = OP_ILLEGAL;
					endcase
					if (op != OP_ILLEGAL) begin
						rsp.imm    = imm_b;
						rsp.target = req.pc + imm_b;
					end
				end
				OPC_JAL: begin
					op = OP_JAL;
					rsp.imm    = imm_j;
					rsp.target = req.pc + imm_j;
				end
				OPC_JALR: begin
					op = OP_JALR;
					rsp.imm = imm_i;
				end
				OPC_FENCE: begin
					op = OP_FENCE;
					rsp.fence_pred = w[27:24];
					rsp.fence_succ = w[23:20];
				end
				OPC_SYSTEM: begin
					if (w[31:20] == SYS_ECALL) begin
						op = OP_ECALL;
					end else if (w[31:20] == SYS_EBREAK) begin
						op = OP_EBREAK;
					end
					if (op != OP_ILLEGAL) begin
						rsp.imm = imm_i;
					end
				end
				default: op = OP_ILLEGAL;
			endcase
			rsp.op = op;
			return rsp;
		endfunction

		function void note_request(dec_req_t req);
			pending_decodes.push_back(decode_insn(req));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s mismatch: expected %h, got %h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(dec_rsp_t got);
			dec_rsp_t want;
			if (pending_decodes.size() == 0) begin
				$error("result %h arrived with no request outstanding", got);
				mismatches++;
				return;
			end
			want = pending_decodes.pop_front();
			compare_field("op", 32'(want.op), 32'(got.op));
			compare_field("rd", 32'(want.rd), 32'(got.rd));
			compare_field("rs1", 32'(want.rs1), 32'(got.rs1));
			compare_field("rs2", 32'(want.rs2), 32'(got.rs2));
			compare_field("imm", want.imm, got.imm);
			compare_field("target", want.target, got.target);
			compare_field("fence_pred", 32'(want.fence_pred), 32'(got.fence_pred));
			compare_field("fence_succ", 32'(want.fence_succ), 32'(got.fence_succ));
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_ready;
	dec_req_t in_data = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	dec_rsp_t out_data;

	// Set during the steady stretch; both channels stop stalling then.
	bit steady = 1'b0;

	decode_scoreboard decode_check = new();

	rv32i_instruction_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decides whether a channel sits out this cycle.
	function automatic bit idle_now();
		return !steady && ($urandom_range(99) < IDLE_PERCENT);
	endfunction

	// Picks funct7 so that both paired operations and the illegal
	// encodings in between are all reached.
	function automatic logic [6:0] pick_funct7();
		int roll;
		roll = $urandom_range(9);
		if (roll < 4) begin
			return F7_BASE;
		end else if (roll < 8) begin
			return F7_ALT;
		end
		return 7'($urandom);
	endfunction

	// Builds a random instruction word. Most are well-formed for one of
	// the major opcodes with random content; the rest are raw noise.
	function automatic logic [31:0] make_random_insn();
		logic [31:0] w;
		int          roll;
		w = $urandom;
		if ($urandom_range(99) < 10) begin
			return w;
		end
		case ($urandom_range(10))
			0: w[6:0] = OPC_LUI;
			1: w[6:0] = OPC_AUIPC;
			2: begin
				w[6:0]   = OPC_REG;
				w[31:25] = pick_funct7();
			end
			3: w[6:0] = OPC_STORE;
			4: begin
				w[6:0] = OPC_IMM;
				// Of the shift immediates, only srli and srai care about funct7.
				if (w[14:12] == 3'd1 || w[14:12] == 3'd5) begin
					w[31:25] = pick_funct7();
				end
			end
			5: w[6:0] = OPC_LOAD;
			6: w[6:0] = OPC_BRANCH;
			7: w[6:0] = OPC_JAL;
			8: w[6:0] = OPC_JALR;
			9: w[6:0] = OPC_FENCE;
			default: begin
				w[6:0] = OPC_SYSTEM;
				roll = $urandom_range(2);
				if (roll == 0) begin
					w[31:20] = SYS_ECALL;
				end else if (roll == 1) begin
					w[31:20] = SYS_EBREAK;
				end
			end
		endcase
		return w;
	endfunction

	// Offers one request and holds it until the unit takes it. Called just
	// after a rising edge, so each idle cycle and the offer itself each make
	// a single assignment to in_valid in their time step.
	task automatic send_request(input logic [31:0] insn, input logic [31:0] pc);
		dec_req_t req;
		req.insn = insn;
		req.pc   = pc;
		while (idle_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do begin
			@(posedge clk);
		end while (!in_ready);
		decode_check.note_request(req);
	endtask

	// Receiver: checks a result at every edge that accepts one and then
	// decides whether to stall the next cycle. Values are read just after
	// the edge, before the unit's own updates of that edge land.
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				decode_check.check_result(out_data);
			end
			out_ready <= !idle_now();
		end
	end

	// Watchdog: ends the run if neither channel moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("rv32i_instruction_decoder_unit test failed");
				$finish;
			end
		end
	end

	// Stimulus: reset, the directed corners, the random requests, then the
	// drain and the verdict.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Upper immediates with every upper bit set and a single low one.
		send_request({20'hfffff, 5'd1, OPC_LUI}, 32'h0000_0000);
		send_request({20'h00001, 5'd0, OPC_AUIPC}, 32'hffff_ffff);
		// add and sub, and an add encoding with a stray funct7 bit.
		send_request({F7_BASE, 10'h0, 3'd0, 5'd0, OPC_REG}, 32'h0);
		send_request({F7_ALT, 5'd31, 5'd31, 3'd0, 5'd31, OPC_REG}, 32'h0);
		send_request({7'h01, 10'h0, 3'd0, 5'd0, OPC_REG}, 32'h0);
		// srl with a bad funct7, sra, and sll whose funct7 is never looked at.
		send_request({7'h7f, 10'h3ff, 3'd5, 5'd3, OPC_REG}, 32'h0);
		send_request({F7_ALT, 10'h2a5, 3'd5, 5'd7, OPC_REG}, 32'h0);
		send_request({7'h7f, 10'h3ff, 3'd1, 5'd31, OPC_REG}, 32'h0);
		// andi keeps its whole immediate.
		send_request({12'hfff, 5'd0, 3'd7, 5'd1, OPC_IMM}, 32'h0);
		// Shift immediates: the amount is only the low five bits of the field.
		send_request({7'h7f, 5'd31, 5'd2, 3'd1, 5'd2, OPC_IMM}, 32'h0);
		send_request({F7_ALT, 5'd31, 5'd2, 3'd5, 5'd2, OPC_IMM}, 32'h0);
		send_request({7'h21, 5'd4, 5'd2, 3'd5, 5'd2, OPC_IMM}, 32'h0);
		// Most negative store offset, then an unused store width.
		send_request({7'h40, 5'd1, 5'd2, 3'd2, 5'd0, OPC_STORE}, 32'h0);
		send_request({7'h3f, 5'd1, 5'd2, 3'd3, 5'd31, OPC_STORE}, 32'h0);
		// An unused load width.
		send_request({12'h7ff, 5'd1, 3'd6, 5'd1, OPC_LOAD}, 32'h0);
		// Largest forward branch from near the top of memory wraps around.
		send_request({7'h3f, 5'd1, 5'd2, 3'd0, 5'h1f, OPC_BRANCH}, 32'hffff_ff00);
		// Largest backward branch from address zero also wraps.
		send_request({7'h40, 5'd1, 5'd2, 3'd7, 5'h00, OPC_BRANCH}, 32'h0000_0000);
		send_request({7'h00, 5'd1, 5'd2, 3'd2, 5'h04, OPC_BRANCH}, 32'h0000_1000);
		// jal with the largest forward offset, landing just below the top of memory.
		send_request({1'b0, 10'h3ff, 1'b1, 8'hff, 5'd1, OPC_JAL}, 32'hfff0_0000);
		// jalr ignores funct3.
		send_request({12'h800, 5'd5, 3'd7, 5'd1, OPC_JALR}, 32'h0);
		// fence with every other bit set.
		send_request({4'hf, 4'ha, 4'h5, 5'd31, 3'd7, 5'd31, OPC_FENCE}, 32'h0);
		// ecall with junk in rd, rs1 and funct3, ebreak, and an illegal one.
		send_request({SYS_ECALL, 5'd31, 3'd7, 5'd31, OPC_SYSTEM}, 32'h0);
		send_request({SYS_EBREAK, 5'd0, 3'd0, 5'd0, OPC_SYSTEM}, 32'h0);
		send_request({12'hfff, 5'd0, 3'd0, 5'd0, OPC_SYSTEM}, 32'h0);
		// All ones and all zeros.
		send_request(32'hffff_ffff, 32'hffff_ffff);
		send_request(32'h0000_0000, 32'h0000_0000);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			steady = (i >= STEADY_FIRST && i < STEADY_LAST);
			send_request(make_random_insn(), $urandom);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// Wait for every decode, then keep the clock running to catch strays.
		while (decode_check.pending_decodes.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (decode_check.mismatches == 0) begin
			$display("rv32i_instruction_decoder_unit test passed");
		end else begin
			$display("rv32i_instruction_decoder_unit test failed");
		end
		$finish;
	end

endmodule

@@ rv32i_instruction_decoder_unit.f @@
src/rv32i_dec_pkg.sv
src/rv32i_dec_logic.sv
src/rv32i_instruction_decoder_unit.sv
src/rv32i_dec_checker.sv
verif/rv32i_instruction_decoder_unit_test.sv
